### hw/rtl/rb2d_pkg.sv
package rb2d_pkg;

	// fixed point format defaults
	localparam int FRAC_BITS_DEF = 16;
	localparam int DT_SHIFT      = 16;
	localparam int GSCALE_SHIFT  = 8;
	localparam int SINE_SHIFT    = 15;

	// configuration port geometry
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// signed 32-bit limits
	localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
	localparam logic [31:0] SAT_MIN = 32'h8000_0000;

	// register reset values
	localparam logic [31:0] INV_MASS_RST    = 32'd65536;
	localparam logic [30:0] MAX_SPD_X_RST   = 31'd26214400;
	localparam logic [30:0] MAX_SPD_Y_RST   = 31'd32768000;
	localparam logic [30:0] GRAV_ACCEL_RST  = 31'd65536000;
	localparam logic [15:0] GRAV_SCALE_RST  = 16'd256;
	localparam logic [23:0] FRIC_RST        = 24'd983040;
	localparam logic        GRAV_EN_RST     = 1'b1;

	// register map, one word each
	typedef enum logic [2:0] {
		REG_INV_MASS,
		REG_MAX_SPD_X,
		REG_MAX_SPD_Y,
		REG_GRAV_ACCEL,
		REG_GRAV_SCALE,
		REG_FRIC,
		REG_GRAV_EN
	} rb2d_reg_t;

	typedef struct packed {
		logic [31:0] inverse_mass;
		logic [30:0] max_speed_x;
		logic [30:0] max_speed_y;
		logic [30:0] gravity_accel;
		logic [15:0] gravity_scale;
		logic [23:0] friction_coeff;
		logic        gravity_enable;
	} rb2d_cfg_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic [15:0]        delta_time;
		logic               grounded;
		logic               on_slope;
		logic               moving_input;
		logic signed [15:0] slope_sine;
		logic               paused;
	} rb2d_in_t;

	typedef struct packed {
		logic signed [31:0] position_x;
		logic signed [31:0] position_y;
		logic signed [31:0] velocity_x;
		logic signed [31:0] velocity_y;
	} rb2d_out_t;

	// product shift selection
	typedef enum logic [1:0] {
		SH_FRAC,
		SH_DT,
		SH_GSCALE,
		SH_SINE
	} rb2d_shift_t;

	// request to the shared multiply-accumulate unit
	typedef struct packed {
		logic signed [32:0] a;
		logic signed [32:0] b;
		rb2d_shift_t        sh;
		logic signed [31:0] addend;
		logic               sub;
	} rb2d_alu_req_t;

	// sequencer steps
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_AX,
		ST_VX,
		ST_AY,
		ST_VY,
		ST_GRAV,
		ST_VY_G,
		ST_CLAMP,
		ST_FRIC_T,
		ST_FRIC_K,
		ST_FRIC_V,
		ST_SNAP,
		ST_PX,
		ST_PY,
		ST_DONE
	} rb2d_step_t;

endpackage

### hw/rtl/rb2d_alu.sv
module rb2d_alu import rb2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  rb2d_alu_req_t      req,
	output logic signed [31:0] result
);

	logic signed [65:0] prod_s1;
	rb2d_shift_t        sh_s1;
	logic signed [31:0] addend_s1;
	logic               sub_s1;
	logic signed [65:0] shifted;
	logic [66:0]        ext_add;
	logic [66:0]        ext_prod;
	logic [66:0]        sum;

	// multiply stage
	always_ff @(posedge clk) begin
		prod_s1   <= req.a * req.b;
		sh_s1     <= req.sh;
		addend_s1 <= req.addend;
		sub_s1    <= req.sub;
	end

	// floor shift of the product
	always_comb begin
		case (sh_s1)
			SH_FRAC:   shifted = prod_s1 >>> FRAC_BITS;
			SH_DT:     shifted = prod_s1 >>> DT_SHIFT;
			SH_GSCALE: shifted = prod_s1 >>> GSCALE_SHIFT;
			SH_SINE:   shifted = prod_s1 >>> SINE_SHIFT;
			default:   shifted = prod_s1;
		endcase
	end

	// accumulate and saturate to 32 bits
	assign ext_add  = {{35{addend_s1[31]}}, addend_s1};
	assign ext_prod = {shifted[65], shifted};
	assign sum      = sub_s1 ? (ext_add - ext_prod) : (ext_add + ext_prod);

	always_comb begin
		if ((&sum[66:31]) || !(|sum[66:31])) begin
			result = sum[31:0];
		end else if (sum[66]) begin
			result = SAT_MIN;
		end else begin
			result = SAT_MAX;
		end
	end

endmodule

### hw/rtl/rb2d_cfg.sv
module rb2d_cfg import rb2d_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output rb2d_cfg_t          cfg
);

	rb2d_cfg_t cfg_q;
	rb2d_reg_t idx;
	logic      wr_en;

	assign pready = 1'b1;
	assign idx    = rb2d_reg_t'(paddr[PADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inverse_mass   <= INV_MASS_RST;
			cfg_q.max_speed_x    <= MAX_SPD_X_RST;
			cfg_q.max_speed_y    <= MAX_SPD_Y_RST;
			cfg_q.gravity_accel  <= GRAV_ACCEL_RST;
			cfg_q.gravity_scale  <= GRAV_SCALE_RST;
			cfg_q.friction_coeff <= FRIC_RST;
			cfg_q.gravity_enable <= GRAV_EN_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_INV_MASS:   cfg_q.inverse_mass   <= pwdata;
				REG_MAX_SPD_X:  cfg_q.max_speed_x    <= pwdata[30:0];
				REG_MAX_SPD_Y:  cfg_q.max_speed_y    <= pwdata[30:0];
				REG_GRAV_ACCEL: cfg_q.gravity_accel  <= pwdata[30:0];
				REG_GRAV_SCALE: cfg_q.gravity_scale  <= pwdata[15:0];
				REG_FRIC:       cfg_q.friction_coeff <= pwdata[23:0];
				REG_GRAV_EN:    cfg_q.gravity_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (idx)
			REG_INV_MASS:   prdata = cfg_q.inverse_mass;
			REG_MAX_SPD_X:  prdata = {1'b0, cfg_q.max_speed_x};
			REG_MAX_SPD_Y:  prdata = {1'b0, cfg_q.max_speed_y};
			REG_GRAV_ACCEL: prdata = {1'b0, cfg_q.gravity_accel};
			REG_GRAV_SCALE: prdata = {16'd0, cfg_q.gravity_scale};
			REG_FRIC:       prdata = {8'd0, cfg_q.friction_coeff};
			REG_GRAV_EN:    prdata = {31'd0, cfg_q.gravity_enable};
			default:        prdata = '0;
		endcase
	end

endmodule

### hw/rtl/rb2d_seq.sv
module rb2d_seq import rb2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rb2d_cfg_t          cfg,
	input  logic               item_valid,
	output logic               item_stall,
	input  rb2d_in_t           item,
	output logic               result_valid,
	input  logic               result_stall,
	output rb2d_out_t          result,
	output rb2d_alu_req_t      alu_req,
	input  logic signed [31:0] alu_res
);

	localparam int          K007_INT = ((7 << FRAC_BITS) + 50) / 100;
	localparam int          K001_INT = ((1 << FRAC_BITS) + 50) / 100;
	localparam logic [32:0] K007     = 33'(K007_INT);
	localparam logic [32:0] K001     = 33'(K001_INT);

	rb2d_step_t step_q, step_d;
	logic       phase_q, phase_d;
	logic       out_valid_q;
	rb2d_out_t  out_q;
	rb2d_in_t   in_q;

	logic signed [31:0] t_q, wx_q, wy_q;
	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	logic        accept;
	logic        can_load;
	logic        is_mul;
	logic        airborne;
	logic        slope_only;
	logic [31:0] neg_t;
	logic [32:0] abs_wx, abs_wy;
	logic [31:0] wx_clamp, wy_clamp;
	logic [32:0] dt_op;

	assign accept     = item_valid && !item_stall;
	assign can_load   = !out_valid_q || !result_stall;
	assign airborne   = !in_q.grounded && !in_q.on_slope;
	assign slope_only = in_q.on_slope && !in_q.grounded;
	assign dt_op      = {17'd0, in_q.delta_time};

	assign result_valid = out_valid_q;
	assign result       = out_q;

	// saturating negation and magnitudes
	assign neg_t  = (t_q == SAT_MIN) ? SAT_MAX : (32'd0 - t_q);
	assign abs_wx = wx_q[31] ? (33'd0 - {1'b1, wx_q}) : {1'b0, wx_q};
	assign abs_wy = wy_q[31] ? (33'd0 - {1'b1, wy_q}) : {1'b0, wy_q};

	// speed limits
	always_comb begin
		wx_clamp = wx_q;
		if (abs_wx > {2'b00, cfg.max_speed_x}) begin
			wx_clamp = wx_q[31] ? (32'd0 - {1'b0, cfg.max_speed_x}) : {1'b0, cfg.max_speed_x};
		end
		wy_clamp = wy_q;
		if (wy_q > $signed({1'b0, cfg.max_speed_y})) begin
			wy_clamp = {1'b0, cfg.max_speed_y};
		end
	end

	// step register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			step_q  <= step_d;
			phase_q <= phase_d;
		end
	end

	// next step
	always_comb begin
		step_d     = step_q;
		phase_d    = 1'b0;
		is_mul     = 1'b0;
		item_stall = 1'b1;
		unique case (step_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					step_d = item.paused ? ST_DONE : ST_AX;
				end
			end
			ST_CLAMP: begin
				step_d = in_q.moving_input ? ST_PX : ST_FRIC_T;
			end
			ST_SNAP: begin
				step_d = ST_PX;
			end
			ST_DONE: begin
				if (can_load) begin
					step_d = ST_IDLE;
				end
			end
			default: begin
				is_mul  = 1'b1;
				phase_d = !phase_q;
				if (phase_q) begin
					unique case (step_q)
						ST_AX:     step_d = ST_VX;
						ST_VX:     step_d = ST_AY;
						ST_AY:     step_d = ST_VY;
						ST_VY:     step_d = (airborne && cfg.gravity_enable) ? ST_GRAV : ST_CLAMP;
						ST_GRAV:   step_d = ST_VY_G;
						ST_VY_G:   step_d = ST_CLAMP;
						ST_FRIC_T: step_d = in_q.grounded ? ST_FRIC_V : ST_FRIC_K;
						ST_FRIC_K: step_d = ST_FRIC_V;
						ST_FRIC_V: step_d = ST_SNAP;
						ST_PX:     step_d = ST_PY;
						ST_PY:     step_d = ST_DONE;
						default:   step_d = ST_IDLE;
					endcase
				end
			end
		endcase
	end

	// operand select for the shared unit
	always_comb begin
		alu_req.a      = {t_q[31], t_q};
		alu_req.b      = dt_op;
		alu_req.sh     = SH_DT;
		alu_req.addend = '0;
		alu_req.sub    = 1'b0;
		case (step_q)
			ST_AX: begin
				alu_req.a  = {in_q.force_x[31], in_q.force_x};
				alu_req.b  = {1'b0, cfg.inverse_mass};
				alu_req.sh = SH_FRAC;
			end
			ST_AY: begin
				alu_req.a  = {in_q.force_y[31], in_q.force_y};
				alu_req.b  = {1'b0, cfg.inverse_mass};
				alu_req.sh = SH_FRAC;
			end
			ST_VX:   alu_req.addend = wx_q;
			ST_VY:   alu_req.addend = wy_q;
			ST_GRAV: begin
				alu_req.a  = {2'b00, cfg.gravity_accel};
				alu_req.b  = {17'd0, cfg.gravity_scale};
				alu_req.sh = SH_GSCALE;
			end
			ST_VY_G: begin
				alu_req.addend = wy_q;
				alu_req.sub    = 1'b1;
			end
			ST_FRIC_T: begin
				if (slope_only) begin
					alu_req.a  = {2'b00, cfg.gravity_accel};
					alu_req.b  = {{17{in_q.slope_sine[15]}}, in_q.slope_sine};
					alu_req.sh = SH_SINE;
				end else begin
					alu_req.a  = {wx_q[31], wx_q};
					alu_req.b  = {9'd0, cfg.friction_coeff};
					alu_req.sh = SH_FRAC;
				end
			end
			ST_FRIC_K: begin
				alu_req.b  = airborne ? K007 : {9'd0, cfg.friction_coeff};
				alu_req.sh = SH_FRAC;
			end
			ST_FRIC_V: begin
				alu_req.a      = slope_only ? {t_q[31], t_q} : {neg_t[31], neg_t};
				alu_req.addend = wx_q;
			end
			ST_PX: begin
				alu_req.a      = {wx_q[31], wx_q};
				alu_req.addend = pos_x_q;
			end
			ST_PY: begin
				alu_req.a      = {wy_q[31], wy_q};
				alu_req.addend = pos_y_q;
			end
			default: ;
		endcase
	end

	// working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= item;
			wx_q <= vel_x_q;
			wy_q <= item.grounded ? 32'sd0 : vel_y_q;
		end else if (step_q == ST_CLAMP) begin
			wx_q <= wx_clamp;
			wy_q <= wy_clamp;
		end else if (step_q == ST_SNAP) begin
			if (abs_wx < K001 && (!slope_only || abs_wy < K001)) begin
				wx_q <= '0;
				if (slope_only) begin
					wy_q <= '0;
				end
			end
		end else if (phase_q) begin
			case (step_q)
				ST_AX, ST_AY, ST_GRAV, ST_FRIC_T, ST_FRIC_K: t_q <= alu_res;
				ST_VX, ST_FRIC_V: wx_q <= alu_res;
				ST_VY, ST_VY_G:   wy_q <= alu_res;
				default: ;
			endcase
		end
	end

	// kept body state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
		end else if (phase_q && step_q == ST_PX) begin
			pos_x_q <= alu_res;
		end else if (phase_q && step_q == ST_PY) begin
			pos_y_q <= alu_res;
			vel_x_q <= wx_q;
			vel_y_q <= wy_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_q == ST_DONE && can_load) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == ST_DONE && can_load) begin
			out_q.position_x <= pos_x_q;
			out_q.position_y <= pos_y_q;
			out_q.velocity_x <= vel_x_q;
			out_q.velocity_y <= vel_y_q;
		end
	end

	// a new result only follows the final step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(step_q == ST_DONE))
		else $error("result raised outside the final step");

	// the half-step phase only runs in multiply steps
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> (step_q != ST_IDLE && step_q != ST_CLAMP &&
			step_q != ST_SNAP && step_q != ST_DONE))
		else $error("phase set outside a multiply step");

	// vertical velocity respects the limit right after clamping
	assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_CLAMP |=> wy_q <= $signed({1'b0, cfg.max_speed_y}))
		else $error("vertical velocity above limit after clamp");

	// a paused transaction leaves the body state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.paused |=> $stable(pos_x_q) && $stable(pos_y_q) &&
			$stable(vel_x_q) && $stable(vel_y_q))
		else $error("paused transaction changed body state");

	// the multiply steps are never entered from idle without a transaction
	assert property (@(posedge clk) disable iff (!arst_n)
		step_q == ST_IDLE && !item_valid |=> step_q == ST_IDLE)
		else $error("sequencer left idle without a transaction");

	// the input stays closed during multiply steps
	assert property (@(posedge clk) disable iff (!arst_n)
		is_mul |-> item_stall)
		else $error("input open during a multiply step");

endmodule

### hw/rtl/rigid_body_2d_euler_step.sv
// 2d rigid body semi-implicit euler step, state in signed q16.16
// a paused transaction goes straight to the final step, any other runs through
// the multiply steps; a new transaction is taken only once the last has left
// the final step, as the single shared multiply-accumulate unit serves each of
// up to 11 dependent products in turn
// reset: velocity and position clear to zero, registers take their reset values
module rigid_body_2d_euler_step import rb2d_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  rb2d_in_t           item,
	output logic               result_valid,
	input  logic               result_stall,
	output rb2d_out_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	rb2d_cfg_t          cfg;
	rb2d_alu_req_t      alu_req;
	logic signed [31:0] alu_res;

	// configuration registers
	rb2d_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step sequencer and body state
	rb2d_seq #(
		.FRAC_BITS (FRAC_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.alu_req      (alu_req),
		.alu_res      (alu_res)
	);

	// shared multiply-accumulate unit
	rb2d_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.req    (alu_req),
		.result (alu_res)
	);

endmodule

### dv/rigid_body_2d_euler_step_tb.sv
module rigid_body_2d_euler_step_tb;
	import rb2d_pkg::*;

	localparam int     FRAC            = FRAC_BITS_DEF;
	localparam longint K_AIR_DRAG      = ((longint'(7) << FRAC) + 50) / 100;
	localparam longint K_SNAP          = ((longint'(1) << FRAC) + 50) / 100;
	localparam int     SETTLE_CYCLES   = 40;
	localparam int     PHASES          = 12;
	localparam int     TICKS_PER_PHASE = 80;
	localparam int     FRAME_DT        = 1092;

	logic               clk;
	logic               arst_n;
	logic               item_valid = 1'b0;
	logic               item_stall;
	rb2d_in_t           item = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	rb2d_out_t          result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	// body state and register copies kept by the predictor
	longint body_vx = 0;
	longint body_vy = 0;
	longint body_px = 0;
	longint body_py = 0;
	longint cfg_inv_mass   = INV_MASS_RST;
	longint cfg_max_x      = MAX_SPD_X_RST;
	longint cfg_max_y      = MAX_SPD_Y_RST;
	longint cfg_grav_accel = GRAV_ACCEL_RST;
	longint cfg_grav_scale = GRAV_SCALE_RST;
	longint cfg_fric       = FRIC_RST;
	longint cfg_grav_en    = GRAV_EN_RST;

	rb2d_in_t  pending_ticks[$];
	rb2d_out_t expected_states[$];
	logic      item_taken = 1'b0;
	int        send_idle_pct;
	int        recv_idle_pct;
	int        err_count;

	rigid_body_2d_euler_step dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic longint sat32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint scale_dt(input longint v, input longint dt);
		return (v * dt) >>> DT_SHIFT;
	endfunction

	function automatic longint magnitude(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	// one semi-implicit euler tick on the predictor state
	function automatic rb2d_out_t predict_step(input rb2d_in_t it);
		longint    vx, vy, fx, fy, dt, sine, ax, ay, g, t, f;
		logic      airborne;
		rb2d_out_t r;
		if (!it.paused) begin
			vx = body_vx;
			vy = body_vy;
			fx = longint'($signed(it.force_x));
			fy = longint'($signed(it.force_y));
			dt = longint'(it.delta_time);
			sine = longint'($signed(it.slope_sine));
			airborne = !it.grounded && !it.on_slope;
			if (it.grounded)
				vy = 0;
			// applied force
			ax = sat32((fx * cfg_inv_mass) >>> FRAC);
			ay = sat32((fy * cfg_inv_mass) >>> FRAC);
			vx = sat32(vx + scale_dt(ax, dt));
			vy = sat32(vy + scale_dt(ay, dt));
			// gravity only in the air
			if (airborne && cfg_grav_en != 0) begin
				g = sat32((cfg_grav_accel * cfg_grav_scale) >>> GSCALE_SHIFT);
				vy = sat32(vy - scale_dt(g, dt));
			end
			// speed limits
			if (magnitude(vx) > cfg_max_x)
				vx = (vx < 0) ? -cfg_max_x : cfg_max_x;
			if (vy > cfg_max_y)
				vy = cfg_max_y;
			// friction, first matching contact mode wins
			if (!it.moving_input) begin
				if (airborne) begin
					t = sat32((vx * cfg_fric) >>> FRAC);
					t = sat32((t * K_AIR_DRAG) >>> FRAC);
					f = sat32(-t);
					vx = sat32(vx + scale_dt(f, dt));
					if (magnitude(vx) < K_SNAP)
						vx = 0;
				end else if (it.grounded) begin
					t = sat32((vx * cfg_fric) >>> FRAC);
					f = sat32(-t);
					vx = sat32(vx + scale_dt(f, dt));
					if (magnitude(vx) < K_SNAP)
						vx = 0;
				end else begin
					t = sat32((cfg_grav_accel * sine) >>> SINE_SHIFT);
					f = sat32((t * cfg_fric) >>> FRAC);
					vx = sat32(vx + scale_dt(f, dt));
					if (magnitude(vx) < K_SNAP && magnitude(vy) < K_SNAP) begin
						vx = 0;
						vy = 0;
					end
				end
			end
			// position from the new velocity
			body_px = sat32(body_px + scale_dt(vx, dt));
			body_py = sat32(body_py + scale_dt(vy, dt));
			body_vx = vx;
			body_vy = vy;
		end
		r.position_x = 32'(body_px);
		r.position_y = 32'(body_py);
		r.velocity_x = 32'(body_vx);
		r.velocity_y = 32'(body_vy);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		err_count++;
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
	endtask

	// register write: setup then access cycle
	task automatic cfg_write(input rb2d_reg_t idx, input logic [31:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_INV_MASS:   cfg_inv_mass   = longint'(data);
			REG_MAX_SPD_X:  cfg_max_x      = longint'(data[30:0]);
			REG_MAX_SPD_Y:  cfg_max_y      = longint'(data[30:0]);
			REG_GRAV_ACCEL: cfg_grav_accel = longint'(data[30:0]);
			REG_GRAV_SCALE: cfg_grav_scale = longint'(data[15:0]);
			REG_FRIC:       cfg_fric       = longint'(data[23:0]);
			REG_GRAV_EN:    cfg_grav_en    = longint'(data[0]);
			default: ;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// hold until every queued tick has been answered, then let the block settle
	task automatic wait_drained();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || item_valid || expected_states.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic rb2d_in_t make_tick(input logic [31:0] fx, input logic [31:0] fy,
			input logic [15:0] dt, input logic g, input logic s, input logic m,
			input logic [15:0] sine, input logic p);
		rb2d_in_t t;
		t.force_x      = fx;
		t.force_y      = fy;
		t.delta_time   = dt;
		t.grounded     = g;
		t.on_slope     = s;
		t.moving_input = m;
		t.slope_sine   = sine;
		t.paused       = p;
		return t;
	endfunction

	// force of random scale, often zero so the body can come to rest
	function automatic logic [31:0] rand_force();
		if ($urandom_range(4) == 0)
			return 32'd0;
		return 32'($signed($urandom) >>> $urandom_range(31));
	endfunction

	function automatic rb2d_in_t rand_tick();
		logic [127:0] raw;
		rb2d_in_t     t;
		raw = {$urandom, $urandom, $urandom, $urandom};
		t = raw[$bits(rb2d_in_t)-1:0];
		// mostly game-like ticks, the rest raw bits
		if ($urandom_range(99) < 80) begin
			t.force_x = rand_force();
			t.force_y = rand_force();
			case ($urandom_range(3))
				0: t.delta_time = 16'(FRAME_DT);
				1: t.delta_time = 16'($urandom_range(4095));
				2: t.delta_time = 16'($urandom_range(1200, 800));
				default: ;
			endcase
			t.grounded     = ($urandom_range(99) < 35);
			t.on_slope     = ($urandom_range(99) < 30);
			t.moving_input = ($urandom_range(99) < 30);
			t.paused       = ($urandom_range(99) < 8);
		end
		return t;
	endfunction

	// input driver
	always @(negedge clk) begin
		if (!item_valid || item_taken) begin
			if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item       <= pending_ticks.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// result receiver stall
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// monitor: predict on accepted ticks, check accepted results
	always @(posedge clk) begin
		rb2d_out_t want;
		item_taken <= item_valid && !item_stall;
		if (arst_n) begin
			if (item_valid && !item_stall)
				expected_states.push_back(predict_step(item));
			if (result_valid && !result_stall) begin
				if (expected_states.size() == 0) begin
					report_mismatch("unexpected result", result.position_x, 32'd0);
				end else begin
					want = expected_states.pop_front();
					if (result.position_x !== want.position_x)
						report_mismatch("position_x", result.position_x, want.position_x);
					if (result.position_y !== want.position_y)
						report_mismatch("position_y", result.position_y, want.position_y);
					if (result.velocity_x !== want.velocity_x)
						report_mismatch("velocity_x", result.velocity_x, want.velocity_x);
					if (result.velocity_y !== want.velocity_y)
						report_mismatch("velocity_y", result.velocity_y, want.velocity_y);
				end
			end
		end
	end

	// stimulus sequence
	initial begin
		logic [31:0] rst_val [7];
		logic [31:0] top_val [7];
		logic [31:0] v;
		rst_val = '{INV_MASS_RST, 32'(MAX_SPD_X_RST), 32'(MAX_SPD_Y_RST),
			32'(GRAV_ACCEL_RST), 32'(GRAV_SCALE_RST), 32'(FRIC_RST), 32'(GRAV_EN_RST)};
		top_val = '{32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h0000_ffff, 32'h00ff_ffff, 32'h0000_0001};
		err_count     = 0;
		send_idle_pct = 11;
		recv_idle_pct = 82;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		arst_n        = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed ticks at reset settings
		pending_ticks.push_back(make_tick(0, 0, 0, 0, 0, 0, 0, 1));
		pending_ticks.push_back(make_tick(32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0));
		pending_ticks.push_back(make_tick(32'h7fff_ffff, 0, 16'hffff, 1, 0, 0, 0, 0));
		pending_ticks.push_back(make_tick(32'h8000_0000, 0, 16'hffff, 1, 0, 0, 0, 0));
		pending_ticks.push_back(make_tick(32'h0010_0000, 0, 16'(FRAME_DT), 0, 0, 0, 0, 0));
		pending_ticks.push_back(make_tick(32'h0010_0000, 0, 16'(FRAME_DT), 0, 0, 1, 0, 0));
		pending_ticks.push_back(make_tick(0, 0, 16'hffff, 0, 1, 0, 16'h7fff, 0));
		pending_ticks.push_back(make_tick(0, 0, 16'hffff, 0, 1, 0, 16'h8000, 0));
		pending_ticks.push_back(make_tick(0, 32'h7fff_ffff, 16'hffff, 1, 1, 0, 16'h4000, 0));
		pending_ticks.push_back(make_tick(32'h7fff_ffff, 32'h8000_0000, 16'hffff, 0, 0, 0,
			16'h7fff, 1));
		repeat (4)
			pending_ticks.push_back(make_tick(0, 0, 16'(FRAME_DT), 1, 0, 0, 0, 0));
		pending_ticks.push_back(make_tick(0, 0, 16'(FRAME_DT), 0, 1, 0, 0, 0));
		pending_ticks.push_back(make_tick(0, 32'h7fff_ffff, 16'hffff, 0, 0, 1, 0, 0));
		pending_ticks.push_back(make_tick(0, 32'h8000_0000, 16'hffff, 0, 0, 1, 0, 0));
		wait_drained();

		// saturation and negation of the most negative value at top settings
		for (int r = 0; r < 7; r++)
			cfg_write(rb2d_reg_t'(r), top_val[r]);
		pending_ticks.push_back(make_tick(32'h8000_0000, 0, 16'hffff, 1, 0, 1, 0, 0));
		pending_ticks.push_back(make_tick(0, 0, 16'hffff, 1, 0, 0, 0, 0));
		pending_ticks.push_back(make_tick(32'h8000_0000, 32'h7fff_ffff, 16'hffff, 0, 0, 0,
			0, 0));
		pending_ticks.push_back(make_tick(0, 0, 16'hffff, 0, 1, 0, 16'h8000, 0));
		pending_ticks.push_back(make_tick(0, 0, 16'hffff, 0, 1, 0, 16'h7fff, 0));
		pending_ticks.push_back(make_tick(32'h8000_0000, 32'h8000_0000, 16'hffff, 1, 1, 0,
			16'h7fff, 0));
		wait_drained();

		// random phases, each under its own register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph / 4)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 82;
				end
				1: begin
					send_idle_pct = 82;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			for (int r = 0; r < 7; r++) begin
				if (ph % 4 == 0)
					v = rst_val[r];
				else if (ph == 1)
					v = top_val[r];
				else if (ph == 2)
					v = 32'd0;
				else begin
					case ($urandom_range(3))
						0: v = 32'd0;
						1: v = top_val[r];
						2: v = rst_val[r];
						default: v = $urandom;
					endcase
				end
				cfg_write(rb2d_reg_t'(r), v);
			end
			repeat (TICKS_PER_PHASE)
				pending_ticks.push_back(rand_tick());
			wait_drained();
		end

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/rb2d_pkg.sv
hw/rtl/rb2d_alu.sv
hw/rtl/rb2d_cfg.sv
hw/rtl/rb2d_seq.sv
hw/rtl/rigid_body_2d_euler_step.sv
dv/rigid_body_2d_euler_step_tb.sv
